>>> rtl/ssd_pkg.sv
// Shared types for the segment-segment distance pipeline.
`default_nettype none

package ssd_pkg;

  // Control that travels with each request down the pipeline.
  typedef struct packed {
    logic vld;
    logic par;
  } ssd_ctl_t;

endpackage

`default_nettype wire

>>> rtl/ssd_if.sv
// Request and result channel interfaces of the segment-segment distance block.
`default_nettype none

interface ssd_in_if #(
  parameter int COORD_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] a0_x;
  logic signed [COORD_WIDTH-1:0] a0_y;
  logic signed [COORD_WIDTH-1:0] a0_z;
  logic signed [COORD_WIDTH-1:0] a1_x;
  logic signed [COORD_WIDTH-1:0] a1_y;
  logic signed [COORD_WIDTH-1:0] a1_z;
  logic signed [COORD_WIDTH-1:0] b0_x;
  logic signed [COORD_WIDTH-1:0] b0_y;
  logic signed [COORD_WIDTH-1:0] b0_z;
  logic signed [COORD_WIDTH-1:0] b1_x;
  logic signed [COORD_WIDTH-1:0] b1_y;
  logic signed [COORD_WIDTH-1:0] b1_z;

  modport source (
    output valid, a0_x, a0_y, a0_z, a1_x, a1_y, a1_z,
    output b0_x, b0_y, b0_z, b1_x, b1_y, b1_z,
    input  ready
  );
  modport sink (
    input  valid, a0_x, a0_y, a0_z, a1_x, a1_y, a1_z,
    input  b0_x, b0_y, b0_z, b1_x, b1_y, b1_z,
    output ready
  );
endinterface

interface ssd_out_if #(
  parameter int COORD_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic [COORD_WIDTH+1:0]        distance;
  logic signed [COORD_WIDTH-1:0] near_a_x;
  logic signed [COORD_WIDTH-1:0] near_a_y;
  logic signed [COORD_WIDTH-1:0] near_a_z;
  logic signed [COORD_WIDTH-1:0] near_b_x;
  logic signed [COORD_WIDTH-1:0] near_b_y;
  logic signed [COORD_WIDTH-1:0] near_b_z;
  logic                          is_parallel;

  modport source (
    output valid, distance, near_a_x, near_a_y, near_a_z,
    output near_b_x, near_b_y, near_b_z, is_parallel,
    input  ready
  );
  modport sink (
    input  valid, distance, near_a_x, near_a_y, near_a_z,
    input  near_b_x, near_b_y, near_b_z, is_parallel,
    output ready
  );
endinterface

`default_nettype wire

>>> rtl/ssd_wmul.sv
// Two-stage signed multiplier built from four half-width partial products.
`default_nettype none

module ssd_wmul #(
  parameter int AW = 68,
  parameter int BW = 68
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic signed [AW-1:0]     a_i,
  input  logic signed [BW-1:0]     b_i,
  output logic signed [AW+BW-1:0]  p_o
);
  localparam int HA = AW / 2;
  localparam int HB = BW / 2;
  localparam int PW = AW + BW;

  logic signed [AW-HA-1:0]         ah;
  logic [HA-1:0]                   al;
  logic signed [BW-HB-1:0]         bh;
  logic [HB-1:0]                   bl;
  logic signed [AW-HA+BW-HB-1:0]   hh_q;
  logic signed [AW-HA+HB:0]        hl_q;
  logic signed [HA+BW-HB:0]        lh_q;
  logic [HA+HB-1:0]                ll_q;
  logic signed [PW-1:0]            p_q;

  assign ah = a_i[AW-1:HA];
  assign al = a_i[HA-1:0];
  assign bh = b_i[BW-1:HB];
  assign bl = b_i[HB-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hh_q <= ah * bh;
      hl_q <= ah * $signed({1'b0, bl});
      lh_q <= $signed({1'b0, al}) * bh;
      ll_q <= al * bl;
      p_q  <= (PW'(hh_q) <<< (HA + HB)) + (PW'(hl_q) <<< HA) + (PW'(lh_q) <<< HB)
              + PW'(ll_q);
    end
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

>>> rtl/ssd_div.sv
// Pipelined point advance: base + trunc(dir * num / den), one dir bit per stage.
`default_nettype none

module ssd_div #(
  parameter int CW = 32,
  parameter int NW = 136
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [CW-1:0] base_i,
  input  logic signed [CW:0]   dir_i,
  input  logic [NW-1:0]        num_i,
  input  logic [NW-1:0]        den_i,
  output logic signed [CW-1:0] pt_o
);
  localparam int RW = NW + 2;

  logic                 neg_q  [0:CW];
  logic [CW-1:0]        mag_q  [0:CW];
  logic [NW-1:0]        num_q  [0:CW];
  logic [NW-1:0]        den_q  [0:CW];
  logic signed [CW-1:0] base_q [0:CW];
  logic [RW-1:0]        rem_q  [0:CW];
  logic [CW-1:0]        quo_q  [0:CW];
  logic [CW-1:0]        off;
  logic signed [CW-1:0] pt_q;

  // Take the magnitude; the sign is put back after the quotient is known.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_q[0]  <= dir_i[CW];
      mag_q[0]  <= dir_i[CW] ? CW'(-dir_i) : dir_i[CW-1:0];
      num_q[0]  <= num_i;
      den_q[0]  <= den_i;
      base_q[0] <= base_i;
      rem_q[0]  <= '0;
      quo_q[0]  <= '0;
    end
  end

  // Shift in dir*num one dir bit at a time; since num <= den the digit is 0..2.
  for (genvar k = 0; k < CW; k++) begin : g_step
    logic [RW-1:0] den1;
    logic [RW-1:0] den2;
    logic [RW-1:0] acc;
    logic [RW-1:0] rem_nx;
    logic [1:0]    dig;

    always_comb begin
      den1 = RW'(den_q[k]);
      den2 = {den1[RW-2:0], 1'b0};
      acc  = {rem_q[k][RW-2:0], 1'b0} + (mag_q[k][CW-1-k] ? RW'(num_q[k]) : '0);
      priority if (acc >= den2) begin
        rem_nx = acc - den2;
        dig    = 2'd2;
      end else if (acc >= den1) begin
        rem_nx = acc - den1;
        dig    = 2'd1;
      end else begin
        rem_nx = acc;
        dig    = 2'd0;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        neg_q[k+1]  <= neg_q[k];
        mag_q[k+1]  <= mag_q[k];
        num_q[k+1]  <= num_q[k];
        den_q[k+1]  <= den_q[k];
        base_q[k+1] <= base_q[k];
        rem_q[k+1]  <= rem_nx;
        quo_q[k+1]  <= {quo_q[k][CW-2:0], 1'b0} + CW'(dig);
      end
    end
  end

  assign off = neg_q[CW] ? (~quo_q[CW] + 1'b1) : quo_q[CW];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pt_q <= base_q[CW] + $signed(off);
    end
  end

  assign pt_o = pt_q;

endmodule

`default_nettype wire

>>> rtl/ssd_sqrt.sv
// Pipelined floored square root, one root bit per stage, with sideband.
`default_nettype none

module ssd_sqrt #(
  parameter int RW = 34,
  parameter int SW = 192
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic [2*RW-1:0]   rad_i,
  input  ssd_pkg::ssd_ctl_t ctl_i,
  input  logic [SW-1:0]     side_i,
  output logic [RW-1:0]     root_o,
  output ssd_pkg::ssd_ctl_t ctl_o,
  output logic [SW-1:0]     side_o
);
  import ssd_pkg::*;

  localparam int XW = 2 * RW + 1;

  logic [XW-1:0] rem_q  [1:RW];
  logic [RW-1:0] root_q [1:RW];
  ssd_ctl_t      ctl_q  [1:RW];
  logic [SW-1:0] side_q [1:RW];

  for (genvar k = 0; k < RW; k++) begin : g_step
    localparam int I = RW - 1 - k;
    logic [XW-1:0] rem_in;
    logic [RW-1:0] root_in;
    ssd_ctl_t      ctl_in;
    logic [SW-1:0] side_in;
    logic [XW-1:0] trial;
    logic [XW-1:0] rem_nx;
    logic [RW-1:0] root_nx;

    if (k == 0) begin : g_first
      assign rem_in  = XW'(rad_i);
      assign root_in = '0;
      assign ctl_in  = ctl_i;
      assign side_in = side_i;
    end else begin : g_next
      assign rem_in  = rem_q[k];
      assign root_in = root_q[k];
      assign ctl_in  = ctl_q[k];
      assign side_in = side_q[k];
    end

    // (R + 2^I)^2 <= X  <=>  X - R^2 >= R*2^(I+1) + 2^(2I)
    always_comb begin
      trial = (XW'(root_in) << (I + 1)) + (XW'(1'b1) << (2 * I));
      if (rem_in >= trial) begin
        rem_nx  = rem_in - trial;
        root_nx = root_in | (RW'(1'b1) << I);
      end else begin
        rem_nx  = rem_in;
        root_nx = root_in;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_q[k+1] <= '0;
      end else if (en_i) begin
        ctl_q[k+1] <= ctl_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1]  <= rem_nx;
        root_q[k+1] <= root_nx;
        side_q[k+1] <= side_in;
      end
    end
  end

  assign root_o = root_q[RW];
  assign ctl_o  = ctl_q[RW];
  assign side_o = side_q[RW];

endmodule

`default_nettype wire

>>> rtl/segment_segment_distance.sv
// Top level: closest points and distance between two 3D segments, fully pipelined.
//
//   channel | role   | handshake   | payload
//   --------+--------+-------------+----------------------------------------------
//   in_i    | sink   | valid/ready | a0, a1, b0, b1 (x, y, z), signed Q16.16
//   out_o   | source | valid/ready | distance Q18.16, near_a, near_b, is_parallel
//
// One request per cycle enters while the skid register is empty. The point advance
// (one direction bit per stage, COORD_WIDTH stages) and the square root (one root
// bit per stage, COORD_WIDTH+2 stages) make up most of the pipeline depth.
// Reset clears only the valid and parallel control bits and the output/skid flags.
// An output register plus a skid register sit at the tail; the whole pipeline
// holds only while the skid register is full, so nothing is dropped or repeated.
`default_nettype none

module segment_segment_distance #(
  parameter int COORD_WIDTH = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  ssd_in_if.sink   in_i,
  ssd_out_if.source out_o
);
  import ssd_pkg::*;

  localparam int CW      = COORD_WIDTH;
  localparam int DW      = CW + 1;        // coordinate differences
  localparam int MW      = 2 * DW;        // one product of differences
  localparam int PW      = MW + 2;        // dot products
  localparam int QW      = 2 * PW + 1;    // determinant and numerators
  localparam int NW      = QW - 1;        // nonnegative fraction terms
  localparam int RW      = CW + 2;        // root width
  localparam int DIV_LAT = CW + 2;
  localparam int SW      = 6 * CW;

  // Dot product slots: a = u.u, b = u.v, c = v.v, d = u.w, e = v.w
  localparam int IA = 0;
  localparam int IB = 1;
  localparam int IC = 2;
  localparam int ID = 3;
  localparam int IE = 4;

  logic en;

  // ---------------------------------------------------------------- stage 1
  logic signed [CW-1:0] in_pt [12];
  logic                 vld_q [1:7];
  logic signed [CW-1:0] p_q   [1:7][12];
  logic signed [DW-1:0] u_q   [1:7][3];
  logic signed [DW-1:0] v_q   [1:7][3];
  logic signed [DW-1:0] w1_q  [3];
  logic                 dga_q [1:7];
  logic                 dgb_q [1:7];

  assign in_pt[0]  = in_i.a0_x;
  assign in_pt[1]  = in_i.a0_y;
  assign in_pt[2]  = in_i.a0_z;
  assign in_pt[3]  = in_i.a1_x;
  assign in_pt[4]  = in_i.a1_y;
  assign in_pt[5]  = in_i.a1_z;
  assign in_pt[6]  = in_i.b0_x;
  assign in_pt[7]  = in_i.b0_y;
  assign in_pt[8]  = in_i.b0_z;
  assign in_pt[9]  = in_i.b1_x;
  assign in_pt[10] = in_i.b1_y;
  assign in_pt[11] = in_i.b1_z;

  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 1; s <= 7; s++) vld_q[s] <= 1'b0;
    end else if (en) begin
      vld_q[1] <= in_i.valid;
      for (int s = 2; s <= 7; s++) vld_q[s] <= vld_q[s-1];
    end
  end

  // Form edge vectors and detect zero-length segments.
  always_ff @(posedge clk_i) begin
    if (en) begin
      p_q[1] <= in_pt;
      for (int j = 0; j < 3; j++) begin
        u_q[1][j] <= DW'(in_pt[3+j]) - DW'(in_pt[j]);
        v_q[1][j] <= DW'(in_pt[9+j]) - DW'(in_pt[6+j]);
        w1_q[j]   <= DW'(in_pt[j]) - DW'(in_pt[6+j]);
      end
      dga_q[1] <= (in_pt[0] == in_pt[3]) && (in_pt[1] == in_pt[4]) && (in_pt[2] == in_pt[5]);
      dgb_q[1] <= (in_pt[6] == in_pt[9]) && (in_pt[7] == in_pt[10])
                  && (in_pt[8] == in_pt[11]);
      for (int s = 2; s <= 7; s++) begin
        p_q[s]   <= p_q[s-1];
        u_q[s]   <= u_q[s-1];
        v_q[s]   <= v_q[s-1];
        dga_q[s] <= dga_q[s-1];
        dgb_q[s] <= dgb_q[s-1];
      end
    end
  end

  // ---------------------------------------------------------- stages 2, 3
  logic signed [MW-1:0] uu_q [3];
  logic signed [MW-1:0] uv_q [3];
  logic signed [MW-1:0] vv_q [3];
  logic signed [MW-1:0] uw_q [3];
  logic signed [MW-1:0] vw_q [3];
  logic signed [PW-1:0] k_q  [3:7][5];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        uu_q[j] <= u_q[1][j] * u_q[1][j];
        uv_q[j] <= u_q[1][j] * v_q[1][j];
        vv_q[j] <= v_q[1][j] * v_q[1][j];
        uw_q[j] <= u_q[1][j] * w1_q[j];
        vw_q[j] <= v_q[1][j] * w1_q[j];
      end
      k_q[3][IA] <= PW'(uu_q[0]) + PW'(uu_q[1]) + PW'(uu_q[2]);
      k_q[3][IB] <= PW'(uv_q[0]) + PW'(uv_q[1]) + PW'(uv_q[2]);
      k_q[3][IC] <= PW'(vv_q[0]) + PW'(vv_q[1]) + PW'(vv_q[2]);
      k_q[3][ID] <= PW'(uw_q[0]) + PW'(uw_q[1]) + PW'(uw_q[2]);
      k_q[3][IE] <= PW'(vw_q[0]) + PW'(vw_q[1]) + PW'(vw_q[2]);
      for (int s = 4; s <= 7; s++) k_q[s] <= k_q[s-1];
    end
  end

  // ---------------------------------------------------------- stages 4, 5
  logic signed [2*PW-1:0] ac5, bb5, be5, cd5, ae5, bd5;

  ssd_wmul #(.AW(PW), .BW(PW)) u_mul_ac (
    .clk_i(clk_i), .en_i(en), .a_i(k_q[3][IA]), .b_i(k_q[3][IC]), .p_o(ac5));
  ssd_wmul #(.AW(PW), .BW(PW)) u_mul_bb (
    .clk_i(clk_i), .en_i(en), .a_i(k_q[3][IB]), .b_i(k_q[3][IB]), .p_o(bb5));
  ssd_wmul #(.AW(PW), .BW(PW)) u_mul_be (
    .clk_i(clk_i), .en_i(en), .a_i(k_q[3][IB]), .b_i(k_q[3][IE]), .p_o(be5));
  ssd_wmul #(.AW(PW), .BW(PW)) u_mul_cd (
    .clk_i(clk_i), .en_i(en), .a_i(k_q[3][IC]), .b_i(k_q[3][ID]), .p_o(cd5));
  ssd_wmul #(.AW(PW), .BW(PW)) u_mul_ae (
    .clk_i(clk_i), .en_i(en), .a_i(k_q[3][IA]), .b_i(k_q[3][IE]), .p_o(ae5));
  ssd_wmul #(.AW(PW), .BW(PW)) u_mul_bd (
    .clk_i(clk_i), .en_i(en), .a_i(k_q[3][IB]), .b_i(k_q[3][ID]), .p_o(bd5));

  // ---------------------------------------------------------------- stage 6
  logic signed [QW-1:0] dd6_q, sn6_q, tn6_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      dd6_q <= QW'(ac5) - QW'(bb5);
      sn6_q <= QW'(be5) - QW'(cd5);
      tn6_q <= QW'(ae5) - QW'(bd5);
    end
  end

  // ------------------------------------------------- stage 7: clamp s first
  logic signed [QW-1:0] sn7_d, sd7_d, tn7_d, td7_d;
  logic signed [QW-1:0] sn7_q, sd7_q, tn7_q, td7_q;
  logic                 par7_d, par7_q;

  always_comb begin
    par7_d = 1'b0;
    sd7_d  = dd6_q;
    td7_d  = dd6_q;
    sn7_d  = sn6_q;
    tn7_d  = tn6_q;
    if (dd6_q == '0) begin
      // parallel lines: pin s to the start of A
      par7_d = 1'b1;
      sn7_d  = '0;
      sd7_d  = QW'(1);
      tn7_d  = QW'(k_q[6][IE]);
      td7_d  = QW'(k_q[6][IC]);
    end else if (sn6_q < 0) begin
      sn7_d = '0;
      tn7_d = QW'(k_q[6][IE]);
      td7_d = QW'(k_q[6][IC]);
    end else if (sn6_q > dd6_q) begin
      sn7_d = dd6_q;
      tn7_d = QW'(k_q[6][IE]) + QW'(k_q[6][IB]);
      td7_d = QW'(k_q[6][IC]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sn7_q  <= sn7_d;
      sd7_q  <= sd7_d;
      tn7_q  <= tn7_d;
      td7_q  <= td7_d;
      par7_q <= par7_d;
    end
  end

  // ----------------------------- stage 8: clamp t, revisit s, pick fallbacks
  logic signed [QW-1:0] sn8, sd8, tn8, x8, ka, kb, kc, kd, ke;
  logic                 edge8;
  logic signed [CW-1:0] base_a_d [3], base_b_d [3];
  logic signed [DW-1:0] dir_a_d  [3], dir_b_d  [3];
  logic [NW-1:0]        num_a_d, den_a_d, num_b_d, den_b_d;
  logic signed [CW-1:0] base_a_q [3], base_b_q [3];
  logic signed [DW-1:0] dir_a_q  [3], dir_b_q  [3];
  logic [NW-1:0]        num_a_q, den_a_q, num_b_q, den_b_q;
  ssd_ctl_t             ctl8_q;

  assign ka = QW'(k_q[7][IA]);
  assign kb = QW'(k_q[7][IB]);
  assign kc = QW'(k_q[7][IC]);
  assign kd = QW'(k_q[7][ID]);
  assign ke = QW'(k_q[7][IE]);

  always_comb begin
    sn8   = sn7_q;
    sd8   = sd7_q;
    tn8   = tn7_q;
    edge8 = 1'b0;
    x8    = '0;
    if (tn7_q < 0) begin
      tn8   = '0;
      x8    = -kd;
      edge8 = 1'b1;
    end else if (tn7_q > td7_q) begin
      tn8   = td7_q;
      x8    = kb - kd;
      edge8 = 1'b1;
    end
    if (edge8) begin
      if (x8 < 0) begin
        sn8 = '0;
      end else if (x8 > ka) begin
        sn8 = sd7_q;
      end else begin
        sn8 = x8;
        sd8 = ka;
      end
    end

    for (int j = 0; j < 3; j++) begin
      base_a_d[j] = p_q[7][j];
      base_b_d[j] = p_q[7][6+j];
      dir_a_d[j]  = u_q[7][j];
      dir_b_d[j]  = v_q[7][j];
    end
    num_a_d = NW'(sn8);
    den_a_d = NW'(sd8);
    num_b_d = NW'(tn8);
    den_b_d = NW'(td7_q);

    if (dga_q[7]) begin
      // A is a point: hold it at A1 and project it onto B
      for (int j = 0; j < 3; j++) begin
        base_a_d[j] = p_q[7][3+j];
        dir_a_d[j]  = '0;
      end
      num_a_d = '0;
      den_a_d = NW'(1);
      if (kc == '0) begin
        num_b_d = '0;
        den_b_d = NW'(1);
      end else begin
        num_b_d = (ke < 0) ? '0 : ((ke > kc) ? NW'(kc) : NW'(ke));
        den_b_d = NW'(kc);
      end
    end else if (dgb_q[7]) begin
      // B is a point: hold it at B1 and project it onto A
      for (int j = 0; j < 3; j++) begin
        base_b_d[j] = p_q[7][9+j];
        dir_b_d[j]  = '0;
      end
      num_b_d = '0;
      den_b_d = NW'(1);
      num_a_d = (-kd < 0) ? '0 : ((-kd > ka) ? NW'(ka) : NW'(-kd));
      den_a_d = NW'(ka);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      base_a_q <= base_a_d;
      base_b_q <= base_b_d;
      dir_a_q  <= dir_a_d;
      dir_b_q  <= dir_b_d;
      num_a_q  <= num_a_d;
      den_a_q  <= den_a_d;
      num_b_q  <= num_b_d;
      den_b_q  <= den_b_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl8_q <= '0;
    end else if (en) begin
      ctl8_q.vld <= vld_q[7];
      ctl8_q.par <= par7_q && !dga_q[7] && !dgb_q[7];
    end
  end

  // ----------------------------------------------------- point advance lanes
  logic signed [CW-1:0] pa [3], pb [3];
  ssd_ctl_t             dq_q [1:DIV_LAT];

  for (genvar j = 0; j < 3; j++) begin : g_lane
    ssd_div #(.CW(CW), .NW(NW)) u_div_a (
      .clk_i(clk_i), .en_i(en), .base_i(base_a_q[j]), .dir_i(dir_a_q[j]),
      .num_i(num_a_q), .den_i(den_a_q), .pt_o(pa[j]));
    ssd_div #(.CW(CW), .NW(NW)) u_div_b (
      .clk_i(clk_i), .en_i(en), .base_i(base_b_q[j]), .dir_i(dir_b_q[j]),
      .num_i(num_b_q), .den_i(den_b_q), .pt_o(pb[j]));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 1; s <= DIV_LAT; s++) dq_q[s] <= '0;
    end else if (en) begin
      dq_q[1] <= ctl8_q;
      for (int s = 2; s <= DIV_LAT; s++) dq_q[s] <= dq_q[s-1];
    end
  end

  // ------------------------------------------- squared distance, three stages
  logic signed [DW-1:0] df_q [3];
  logic [MW-1:0]        sq_q [3];
  logic [PW-1:0]        rad_q;
  logic [SW-1:0]        sd_q [1:3];
  ssd_ctl_t             eq_q [1:3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        df_q[j] <= DW'(pa[j]) - DW'(pb[j]);
        sq_q[j] <= MW'(df_q[j] * df_q[j]);
      end
      rad_q   <= PW'(sq_q[0]) + PW'(sq_q[1]) + PW'(sq_q[2]);
      sd_q[1] <= {pa[0], pa[1], pa[2], pb[0], pb[1], pb[2]};
      sd_q[2] <= sd_q[1];
      sd_q[3] <= sd_q[2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 1; s <= 3; s++) eq_q[s] <= '0;
    end else if (en) begin
      eq_q[1] <= dq_q[DIV_LAT];
      eq_q[2] <= eq_q[1];
      eq_q[3] <= eq_q[2];
    end
  end

  // ------------------------------------------------------------ square root
  logic [RW-1:0] root_t;
  ssd_ctl_t      ctl_t;
  logic [SW-1:0] side_t;

  ssd_sqrt #(.RW(RW), .SW(SW)) u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .rad_i  (rad_q),
    .ctl_i  (eq_q[3]),
    .side_i (sd_q[3]),
    .root_o (root_t),
    .ctl_o  (ctl_t),
    .side_o (side_t)
  );

  // ---------------------------------------------------- output and skid
  logic          out_vld_q, skid_vld_q, out_load;
  logic [RW-1:0] out_root_q, skid_root_q;
  logic [SW-1:0] out_side_q, skid_side_q;
  logic          out_par_q, skid_par_q;

  assign en       = !skid_vld_q;
  assign out_load = !out_vld_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (out_load) begin
      // drain the skid first; the pipeline is held while it is full
      if (skid_vld_q) begin
        out_vld_q  <= 1'b1;
        skid_vld_q <= 1'b0;
      end else begin
        out_vld_q <= ctl_t.vld;
      end
    end else if (ctl_t.vld && !skid_vld_q) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      if (skid_vld_q) begin
        out_root_q <= skid_root_q;
        out_side_q <= skid_side_q;
        out_par_q  <= skid_par_q;
      end else begin
        out_root_q <= root_t;
        out_side_q <= side_t;
        out_par_q  <= ctl_t.par;
      end
    end else if (!skid_vld_q) begin
      skid_root_q <= root_t;
      skid_side_q <= side_t;
      skid_par_q  <= ctl_t.par;
    end
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.distance    = out_root_q;
  assign out_o.near_a_x    = out_side_q[6*CW-1:5*CW];
  assign out_o.near_a_y    = out_side_q[5*CW-1:4*CW];
  assign out_o.near_a_z    = out_side_q[4*CW-1:3*CW];
  assign out_o.near_b_x    = out_side_q[3*CW-1:2*CW];
  assign out_o.near_b_y    = out_side_q[2*CW-1:CW];
  assign out_o.near_b_z    = out_side_q[CW-1:0];
  assign out_o.is_parallel = out_par_q;

  // ------------------------------------------------------------- assertions
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid register holds a request while the output is empty");

  a_det_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[6] |-> !dd6_q[QW-1])
    else $error("determinant went negative");

  a_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl8_q.vld |-> (den_a_q != '0) && (den_b_q != '0))
    else $error("point advance got a zero denominator");

  a_frac_le_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl8_q.vld |-> (num_a_q <= den_a_q) && (num_b_q <= den_b_q))
    else $error("line parameter left the range zero to one");

endmodule

`default_nettype wire
